// ----- rtl/core/fol_pkg.sv -----
// Shared constants, codes and control types of the frequency ordered list unit.
package fol_pkg;

	localparam int DEPTH_DEFAULT       = 16;
	localparam int DATA_WIDTH_DEFAULT  = 32;
	localparam int COUNT_WIDTH_DEFAULT = 16;

	// Fixed field widths of the stream channels
	localparam int OPCODE_W    = 2;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int POSITION_W  = 4;
	localparam int FREQUENCY_W = 16;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_LOCATE = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NOP    = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic capture; // input transfer: register operation and compare
		logic commit;  // apply the update and hand the result over
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [POSITION_W-1:0]  position;
		logic [FREQUENCY_W-1:0] frequency;
	} result_t;

endpackage

// ----- rtl/core/fol_ctrl.sv -----
// Controller: stream handshakes, two-state sequencer and the output register.
module fol_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output fol_pkg::result_t m_result,
	output fol_pkg::cmd_t    cmd,
	input  fol_pkg::result_t dp_result
);
	import fol_pkg::*;

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_UPDATE = 1'b1;

	logic    state_q;
	logic    m_tvalid_q;
	result_t result_q;
	logic    out_free;

	assign out_free    = !m_tvalid_q || m_tready;
	assign s_tready    = (state_q == S_IDLE);
	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.commit  = (state_q == S_UPDATE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					// hold here while the previous result is still not taken
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q <= dp_result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_result = result_q;

endmodule

// ----- rtl/core/fol_datapath.sv -----
// Datapath: entry registers, parallel match, count update and shift-insert.
module fol_datapath #(
	parameter int DEPTH       = fol_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH  = fol_pkg::DATA_WIDTH_DEFAULT,
	parameter int COUNT_WIDTH = fol_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fol_pkg::cmd_t                 cmd,
	input  logic [fol_pkg::OPCODE_W-1:0]  in_opcode,
	input  logic [fol_pkg::VALUE_W-1:0]   in_value,
	output fol_pkg::result_t              result
);
	import fol_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOT_W = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0]  val_q [DEPTH];
	logic [COUNT_WIDTH-1:0] cnt_q [DEPTH];
	logic [TOT_W-1:0]       total_q;

	logic [OPCODE_W-1:0]    op_s1;
	logic [DATA_WIDTH-1:0]  value_s1;
	logic [DEPTH-1:0]       first_s1;

	logic [DATA_WIDTH-1:0]  key;
	logic [DEPTH-1:0]       eq;
	logic [DEPTH-1:0]       first;

	logic                   hit_any;
	logic                   full;
	logic [IDX_W-1:0]       idx;
	logic [COUNT_WIDTH-1:0] cnt_old;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic [DEPTH-1:0]       move_over;
	logic [IDX_W-1:0]       k;
	logic                   do_locate;
	logic                   do_append;
	logic [DEPTH-1:0]       sel_ins;
	logic [DEPTH-1:0]       sel_shift;
	logic [DEPTH-1:0]       sel_app;

	// Match stage: compare the incoming value against every live entry
	assign key = DATA_WIDTH'(in_value);

	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int j = 0; j < DEPTH; j++) begin
			eq[j]    = (TOT_W'(j) < total_q) && (val_q[j] == key);
			first[j] = eq[j] && !seen;
			seen     = seen || eq[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1    <= in_opcode;
			value_s1 <= key;
			first_s1 <= first;
		end
	end

	// Update stage
	assign hit_any = |first_s1;
	assign full    = (total_q == TOT_W'(DEPTH));

	always_comb begin
		idx     = '0;
		cnt_old = '0;
		for (int j = 0; j < DEPTH; j++) begin
			idx     = idx | (first_s1[j] ? IDX_W'(j) : '0);
			cnt_old = cnt_old | (first_s1[j] ? cnt_q[j] : '0);
		end
	end

	assign cnt_new = (&cnt_old) ? cnt_old : cnt_old + 1'b1;

	// Counts are non-increasing from the head, so the earlier entries that the
	// located one overtakes form one run ending just before it.
	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			move_over[j] = (IDX_W'(j) < idx) && (cnt_q[j] <= cnt_new);
		end
		k = idx;
		for (int j = DEPTH - 1; j >= 0; j--) begin
			if (move_over[j]) begin
				k = IDX_W'(j);
			end
		end
	end

	assign do_locate = cmd.commit && (op_s1 == OP_LOCATE) && hit_any;
	assign do_append = cmd.commit && (op_s1 == OP_APPEND) && !full;

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			sel_ins[j]   = do_locate && (IDX_W'(j) == k);
			sel_shift[j] = do_locate && (IDX_W'(j) > k) && (IDX_W'(j) <= idx);
			sel_app[j]   = do_append && (total_q == TOT_W'(j));
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_entry
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (sel_ins[g]) begin
					val_q[g] <= value_s1;
					cnt_q[g] <= cnt_new;
				end else if (sel_app[g]) begin
					val_q[g] <= value_s1;
					cnt_q[g] <= '0;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (sel_ins[g]) begin
					val_q[g] <= value_s1;
					cnt_q[g] <= cnt_new;
				end else if (sel_shift[g]) begin
					val_q[g] <= val_q[g-1];
					cnt_q[g] <= cnt_q[g-1];
				end else if (sel_app[g]) begin
					val_q[g] <= value_s1;
					cnt_q[g] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.commit && (op_s1 == OP_CLEAR)) begin
			total_q <= '0;
		end else if (do_append) begin
			total_q <= total_q + 1'b1;
		end
	end

	always_comb begin
		result.status    = STAT_OK;
		result.position  = '0;
		result.frequency = '0;
		unique case (op_s1)
			OP_CLEAR: begin
				result.status = STAT_OK;
			end
			OP_APPEND: begin
				if (full) begin
					result.status = STAT_FULL;
				end else begin
					result.position = POSITION_W'(total_q);
				end
			end
			OP_LOCATE: begin
				if (hit_any) begin
					result.position  = POSITION_W'(k);
					result.frequency = FREQUENCY_W'(cnt_new);
				end else begin
					result.status = STAT_MISS;
				end
			end
			default: begin
				result.status = STAT_OK;
			end
		endcase
	end

endmodule

// ----- rtl/core/frequency_ordered_list_unit.sv -----
// Top level of the frequency ordered list unit: controller plus datapath.
//
// Keeps up to DEPTH values, each with an access count, in non-increasing
// count order. One operation enters on the slave stream: s_tuser carries the
// opcode (clear, append, locate), s_tdata the value. Exactly one result
// leaves on the master stream: m_tuser carries the status (done or found,
// locate miss, append refused), m_tdata the new position and count.
//
// In the transfer cycle the value is compared against all entries in
// parallel; the update state then bumps the count and does the
// shift-insert. The next operation is taken only once the update is
// through, since the following compare depends on it. The update writes
// the result into the output register, which drives m_tvalid.
//
// Reset empties the list; entry storage itself is not cleared. The output
// register lets a new operation enter while a result waits; if the receiver
// stalls, the unit holds its update cycle until the output register frees.
module frequency_ordered_list_unit #(
	parameter int DEPTH       = fol_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH  = fol_pkg::DATA_WIDTH_DEFAULT,
	parameter int COUNT_WIDTH = fol_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fol_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
	input  logic [fol_pkg::OPCODE_W-1:0]  s_tuser,  // [1:0] opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fol_pkg::M_TDATA_W-1:0] m_tdata,  // [3:0] position, [19:4] frequency
	output logic [fol_pkg::STATUS_W-1:0]  m_tuser   // [1:0] status
);
	import fol_pkg::*;

	cmd_t    cmd;
	result_t dp_result;
	result_t m_result;

	fol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_result  (m_result),
		.cmd       (cmd),
		.dp_result (dp_result)
	);

	fol_datapath #(
		.DEPTH       (DEPTH),
		.DATA_WIDTH  (DATA_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_opcode (s_tuser),
		.in_value  (s_tdata[VALUE_W-1:0]),
		.result    (dp_result)
	);

	assign m_tdata = {(M_TDATA_W - FREQUENCY_W - POSITION_W)'(0),
		m_result.frequency, m_result.position};
	assign m_tuser = m_result.status;

endmodule

// ----- rtl/core/fol_checker.sv -----
// Port-level checks of the frequency ordered list unit and their binding.
module fol_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fol_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [fol_pkg::STATUS_W-1:0]  m_tuser
);
	import fol_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// The update cycle follows every input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken during update cycle");

	// A new result appears only out of an update cycle
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without an update cycle");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_MISS || m_tuser == STAT_FULL))
		else $error("undefined status code");

	// Miss and full carry neither a position nor a count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_MISS || m_tuser == STAT_FULL)
		|-> m_tdata[FREQUENCY_W+POSITION_W-1:0] == '0)
		else $error("miss or full with nonzero payload");

endmodule

bind frequency_ordered_list_unit fol_checker u_fol_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
